>>> src/sngf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the scanline nearest gap fill block.
// No dependencies; every other file refers to this package by scoped names.
package sngf_pkg;

   localparam int WIDTH_CAP_DEFAULT = 4096;
   localparam int CSR_W             = 13;
   localparam int ROW_W             = 12;
   localparam int START_W           = 12;
   localparam int LEN_W             = 13;
   localparam int COLOR_W           = 24;
   localparam int SLOT_COUNT        = 3;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [CSR_W-1:0] ROW_WIDTH_RESET = 13'd800;

   typedef struct packed {
      logic       sampled;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [START_W-1:0] run_start;
      logic [LEN_W-1:0]   run_length;
      logic [ROW_W-1:0]   row_index;
      logic [7:0]         red_out;
      logic [7:0]         green_out;
      logic [7:0]         blue_out;
      logic               last_run;
   } rsp_type;

   // Bits of one queued entry: row plus three slots of
   // {valid, start[cw], stop[cw+1], color}.
   function automatic int entry_width(input int cw);
      entry_width = ROW_W + SLOT_COUNT * (1 + cw + (cw + 1) + COLOR_W);
   endfunction

endpackage

>>> src/sngf_queue.sv
`timescale 1ns / 1ps
// Small register queue between the front and the back of the gap filler.
// Uses sngf_pkg only for the default of its DEPTH parameter.
module sngf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sngf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [IW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == NW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = store_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + IW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + IW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(DEPTH))
      else $error("queue count beyond depth");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty && !do_push |=> empty)
      else $error("queue left empty without a push");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      empty |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");
`endif

endmodule

>>> src/sngf_front.sv
`timescale 1ns / 1ps
// Front of the gap filler: row width register, row tracking and run classification.
// Depends on sngf_pkg; feeds up to three run candidates per pixel into sngf_queue.
module sngf_front #(
   parameter int WIDTH_CAP = sngf_pkg::WIDTH_CAP_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sngf_pkg::CSR_W-1:0]   csr_data,
   input  logic                         req_push,
   output logic                         req_full,
   input  sngf_pkg::req_type            req_data,
   input  logic                         q_full,
   output logic                         q_push,
   output logic [sngf_pkg::entry_width($clog2(WIDTH_CAP))-1:0] q_data
);

   localparam int CW = $clog2(WIDTH_CAP);
   localparam int EW = CW + 1;
   localparam logic [31:0] CAP_W32 = 32'(WIDTH_CAP);

   typedef struct packed {
      logic                           vld;
      logic [CW-1:0]                  start;
      logic [EW-1:0]                  stop;
      logic [sngf_pkg::COLOR_W-1:0]   color;
   } slot_type;

   typedef struct packed {
      logic [sngf_pkg::ROW_W-1:0]     row;
      slot_type [2:0]                 slots;
   } entry_type;

   logic [sngf_pkg::CSR_W-1:0]   row_width_ff;
   logic [CW-1:0]                col_ff, col_in;
   logic [sngf_pkg::ROW_W-1:0]   row_ff, row_in;
   logic                         seen_ff, seen_in;
   logic [CW-1:0]                smp_col_ff, smp_col_in;
   logic [sngf_pkg::COLOR_W-1:0] smp_color_ff, smp_color_in;

   logic                         accept;
   logic [EW-1:0]                width_eff;
   logic [EW-1:0]                col_ext;
   logic [EW-1:0]                mid_sum;
   logic [CW-1:0]                mid;
   logic                         row_end;
   logic                         sampled;
   logic [sngf_pkg::COLOR_W-1:0] new_color;
   entry_type                    entry;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;
   assign q_data    = entry;
   assign q_push    = accept && (entry.slots[0].vld || entry.slots[1].vld
                                 || entry.slots[2].vld);

   // Width of zero acts as one, anything above the maximum acts as the maximum.
   always_comb begin
      if (row_width_ff == '0) begin
         width_eff = EW'(1);
      end else if (32'(row_width_ff) > CAP_W32) begin
         width_eff = EW'(WIDTH_CAP);
      end else begin
         width_eff = EW'(row_width_ff);
      end
   end

   always_comb begin
      sampled   = req_data.sampled;
      new_color = {req_data.red_in, req_data.green_in, req_data.blue_in};
      col_ext   = {1'b0, col_ff};
      mid_sum   = {1'b0, smp_col_ff} + col_ext;
      mid       = mid_sum[EW-1:1];
      row_end   = (col_ext + EW'(1)) >= width_eff;

      entry.row = row_ff;

      // First slot: whole lead-in on the first sample, else left half in old color.
      if (!seen_ff) begin
         entry.slots[0].start = '0;
         entry.slots[0].stop  = col_ext;
         entry.slots[0].color = new_color;
      end else begin
         entry.slots[0].start = smp_col_ff;
         entry.slots[0].stop  = {1'b0, mid};
         entry.slots[0].color = smp_color_ff;
      end
      entry.slots[0].vld = sampled && (entry.slots[0].stop > {1'b0, entry.slots[0].start});

      entry.slots[1].start = mid;
      entry.slots[1].stop  = col_ext;
      entry.slots[1].color = new_color;
      entry.slots[1].vld   = sampled && seen_ff && (col_ff > mid);

      seen_in      = seen_ff || sampled;
      smp_col_in   = sampled ? col_ff : smp_col_ff;
      smp_color_in = sampled ? new_color : smp_color_ff;

      // Tail run to the end of the row.
      entry.slots[2].start = smp_col_in;
      entry.slots[2].stop  = width_eff;
      entry.slots[2].color = smp_color_in;
      entry.slots[2].vld   = row_end && seen_in && (width_eff > {1'b0, smp_col_in});

      col_in = CW'(col_ext + EW'(1));
      row_in = row_ff;
      if (row_end) begin
         col_in     = '0;
         seen_in    = 1'b0;
         smp_col_in = '0;
         row_in     = row_ff + sngf_pkg::ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= sngf_pkg::ROW_WIDTH_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         seen_ff      <= 1'b0;
         smp_col_ff   <= '0;
         smp_color_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            row_width_ff <= csr_data;
         end
         if (accept) begin
            col_ff       <= col_in;
            row_ff       <= row_in;
            seen_ff      <= seen_in;
            smp_col_ff   <= smp_col_in;
            smp_color_ff <= smp_color_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_push && !req_full))
      else $error("entry queued without an accepted pixel");
   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && row_end |=> (col_ff == '0) && !seen_ff)
      else $error("row end did not restart the column");
   a_seen_on_sample: assert property (@(posedge clock) disable iff (reset)
      accept && sampled && !row_end |=> seen_ff && (smp_col_ff == $past(col_ff)))
      else $error("sample not recorded");
`endif

endmodule

>>> src/sngf_back.sv
`timescale 1ns / 1ps
// Back of the gap filler: walks the queued run slots and drives one run per beat.
// Depends on sngf_pkg; reads the head of sngf_queue.
module sngf_back #(
   parameter int WIDTH_CAP = sngf_pkg::WIDTH_CAP_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  logic [sngf_pkg::entry_width($clog2(WIDTH_CAP))-1:0] q_data,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output sngf_pkg::rsp_type    rsp_data
);

   localparam int CW = $clog2(WIDTH_CAP);
   localparam int EW = CW + 1;

   typedef struct packed {
      logic                           vld;
      logic [CW-1:0]                  start;
      logic [EW-1:0]                  stop;
      logic [sngf_pkg::COLOR_W-1:0]   color;
   } slot_type;

   typedef struct packed {
      logic [sngf_pkg::ROW_W-1:0]     row;
      slot_type [2:0]                 slots;
   } entry_type;

   entry_type          head;
   slot_type           pick;
   logic [2:0]         remain;
   logic [2:0]         sel;
   logic               last;
   logic               load;
   logic [2:0]         used_ff, used_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sngf_pkg::rsp_type  rsp_ff, rsp_in;

   assign head      = entry_type'(q_data);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign load      = !q_empty && (!rsp_valid_ff || rsp_pop);
   assign q_pop     = load && last;

   always_comb begin
      remain = {head.slots[2].vld, head.slots[1].vld, head.slots[0].vld} & ~used_ff;
      if (remain[0]) begin
         sel  = 3'b001;
         pick = head.slots[0];
      end else if (remain[1]) begin
         sel  = 3'b010;
         pick = head.slots[1];
      end else begin
         sel  = 3'b100;
         pick = head.slots[2];
      end
      last = ((remain & ~sel) == 3'b000);

      rsp_in.run_start  = sngf_pkg::START_W'(pick.start);
      rsp_in.run_length = sngf_pkg::LEN_W'(pick.stop - {1'b0, pick.start});
      rsp_in.row_index  = head.row;
      rsp_in.red_out    = pick.color[23:16];
      rsp_in.green_out  = pick.color[15:8];
      rsp_in.blue_out   = pick.color[7:0];
      rsp_in.last_run   = last;

      // Mark the slot as sent, or retire the entry on its final run.
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         used_in      = last ? 3'b000 : (used_ff | sel);
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_head_has_run: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (remain != 3'b000))
      else $error("queued entry with no run left");
   a_used_only_on_head: assert property (@(posedge clock) disable iff (reset)
      (used_ff != 3'b000) |-> !q_empty)
      else $error("slot marks kept without a queued entry");
   a_pop_on_load: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid_ff && rsp_ff.last_run)
      else $error("entry retired without its final run");
`endif

endmodule

>>> src/scanline_nearest_gap_fill.sv
`timescale 1ns / 1ps
// Top level of the scanline nearest gap fill block.
// Depends on sngf_pkg, sngf_front, sngf_queue and sngf_back.
//
//   channel | ports                               | beat taken when
//   --------+-------------------------------------+-----------------------
//   pixels  | req_push, req_full, req_data        | req_push && !req_full
//   runs    | rsp_empty, rsp_pop, rsp_data        | rsp_pop && !rsp_empty
//   width   | csr_valid, csr_ready, csr_data      | csr_valid && csr_ready
//
// One pixel is taken per cycle while the four-entry run queue has room.
// The result register holds one run at a time, so a pixel that causes
// runs yields one to three of them; a hole yields none unless it ends a
// row that had a sample, where it yields the tail run.
// A run passes through the queue register and then the result register.
// Synchronous reset; no clearing pass. csr_ready is always high.
module scanline_nearest_gap_fill #(
   parameter int WIDTH_CAP = sngf_pkg::WIDTH_CAP_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  sngf_pkg::req_type           req_data,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output sngf_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sngf_pkg::CSR_W-1:0]  csr_data
);

   localparam int ENTRY_W = sngf_pkg::entry_width($clog2(WIDTH_CAP));

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   logic [ENTRY_W-1:0] q_in_data;
   logic [ENTRY_W-1:0] q_head_data;

   sngf_front #(
      .WIDTH_CAP (WIDTH_CAP)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_in_data)
   );

   sngf_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (sngf_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .head_data (q_head_data),
      .empty     (q_empty)
   );

   sngf_back #(
      .WIDTH_CAP (WIDTH_CAP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_head_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> bench/sngf_run_checker.sv
`timescale 1ns / 1ps
// Run checker for scanline_nearest_gap_fill: watches the pixel, run and width channels,
// predicts the fill runs of every accepted pixel and compares each popped run in order.
// Depends on sngf_pkg only.
module sngf_run_checker #(
   parameter int WIDTH_CAP = sngf_pkg::WIDTH_CAP_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  logic                        req_full,
   input  sngf_pkg::req_type           req_data,
   input  logic                        rsp_empty,
   input  logic                        rsp_pop,
   input  sngf_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [sngf_pkg::CSR_W-1:0]  csr_data,
   output int                          fail_count,
   output int                          pending_runs,
   output int                          runs_checked
);

   localparam int REPORT_LIMIT = 10;

   logic [sngf_pkg::CSR_W-1:0]   row_width;
   int                           column;
   logic [sngf_pkg::ROW_W-1:0]   row_count;
   bit                           seen_sample;
   int                           sample_column;
   logic [sngf_pkg::COLOR_W-1:0] sample_color;
   sngf_pkg::rsp_type            fill_run_q[$];

   function automatic sngf_pkg::rsp_type make_run(input int first, input int stop,
                                        input logic [sngf_pkg::COLOR_W-1:0] rgb,
                                        input logic [sngf_pkg::ROW_W-1:0] row);
      sngf_pkg::rsp_type r;
      r.run_start  = first[sngf_pkg::START_W-1:0];
      r.run_length = sngf_pkg::LEN_W'(stop - first);
      r.row_index  = row;
      r.red_out    = rgb[23:16];
      r.green_out  = rgb[15:8];
      r.blue_out   = rgb[7:0];
      r.last_run   = 1'b0;
      return r;
   endfunction

   task automatic predict_runs(input sngf_pkg::req_type px);
      int                           width;
      int                           col;
      int                           mid;
      int                           n;
      logic [sngf_pkg::COLOR_W-1:0] rgb;
      sngf_pkg::rsp_type            runs [3];
      if (row_width == '0)
         width = 1;
      else if (row_width > WIDTH_CAP)
         width = WIDTH_CAP;
      else
         width = row_width;
      col = column;
      n   = 0;
      rgb = {px.red_in, px.green_in, px.blue_in};
      if (px.sampled) begin
         if (!seen_sample) begin
            if (col > 0) begin
               runs[n] = make_run(0, col, rgb, row_count);
               n++;
            end
         end else begin
            // left half keeps the old color, right half takes the new one
            mid = (sample_column + col) / 2;
            if (mid > sample_column) begin
               runs[n] = make_run(sample_column, mid, sample_color, row_count);
               n++;
            end
            if (col > mid) begin
               runs[n] = make_run(mid, col, rgb, row_count);
               n++;
            end
         end
         seen_sample   = 1'b1;
         sample_column = col;
         sample_color  = rgb;
      end
      if (col + 1 >= width) begin
         // close the row; a tail that starts past a shrunk width is dropped
         if (seen_sample && width > sample_column) begin
            runs[n] = make_run(sample_column, width, sample_color, row_count);
            n++;
         end
         column        = 0;
         seen_sample   = 1'b0;
         sample_column = 0;
         row_count     = row_count + 1'b1;
      end else begin
         column = col + 1;
      end
      if (n > 0)
         runs[n-1].last_run = 1'b1;
      for (int k = 0; k < n; k++)
         fill_run_q.push_back(runs[k]);
   endtask

   task automatic check_run(input sngf_pkg::rsp_type got);
      sngf_pkg::rsp_type want;
      bit                bad;
      if (fill_run_q.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("unexpected run: start %0d len %0d row %0d rgb %h%h%h last %b",
                     got.run_start, got.run_length, got.row_index,
                     got.red_out, got.green_out, got.blue_out, got.last_run);
      end else begin
         want = fill_run_q.pop_front();
         runs_checked++;
         bad = (got.run_start  !== want.run_start)  || (got.run_length !== want.run_length) ||
               (got.row_index  !== want.row_index)  || (got.red_out    !== want.red_out)    ||
               (got.green_out  !== want.green_out)  || (got.blue_out   !== want.blue_out)   ||
               (got.last_run   !== want.last_run);
         if (bad) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
               $display("run %0d mismatch (expected/actual): start %0d/%0d len %0d/%0d",
                        runs_checked, want.run_start, got.run_start,
                        want.run_length, got.run_length);
               $display("   row %0d/%0d rgb %h%h%h/%h%h%h last %b/%b",
                        want.row_index, got.row_index,
                        want.red_out, want.green_out, want.blue_out,
                        got.red_out, got.green_out, got.blue_out,
                        want.last_run, got.last_run);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         row_width     = sngf_pkg::ROW_WIDTH_RESET;
         column        = 0;
         row_count     = '0;
         seen_sample   = 1'b0;
         sample_column = 0;
         sample_color  = '0;
         fill_run_q.delete();
         fail_count    = 0;
         runs_checked  = 0;
      end else begin
         // check before predicting: a run never leaves in its own pixel's cycle
         if (rsp_pop && !rsp_empty)
            check_run(rsp_data);
         if (req_push && !req_full)
            predict_runs(req_data);
         if (csr_valid && csr_ready)
            row_width = csr_data;
      end
      pending_runs = fill_run_q.size();
   end

endmodule

>>> bench/scanline_nearest_gap_fill_tb.sv
`timescale 1ns / 1ps
// Top of the scanline_nearest_gap_fill regression: clock, reset, pixel and width stimulus,
// run receiver and verdict. Depends on sngf_pkg, the block and sngf_run_checker.
module scanline_nearest_gap_fill_tb;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;

   logic                         clock;
   logic                         reset     = 1'b1;
   logic                         req_push  = 1'b0;
   logic                         req_full;
   sngf_pkg::req_type            req_data  = '0;
   logic                         rsp_empty;
   logic                         rsp_pop   = 1'b0;
   sngf_pkg::rsp_type            rsp_data;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [sngf_pkg::CSR_W-1:0]   csr_data  = '0;

   int                 fail_count;
   int                 pending_runs;
   int                 runs_checked;
   int                 pixels_sent   = 0;
   int                 width_writes  = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;
   bit                 hold_request  = 1'b0;

   scanline_nearest_gap_fill u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   sngf_run_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .pending_runs (pending_runs),
      .runs_checked (runs_checked)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   initial begin
      #4_000_000;
      $display("scanline_nearest_gap_fill regression: fail");
      $finish;
   end

   // run receiver: random pops, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [7:0] pick_channel();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0)
         return 8'h00;
      if (r == 1)
         return 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic sngf_pkg::req_type make_pixel(input bit smp, input logic [23:0] rgb);
      sngf_pkg::req_type px;
      px.sampled  = smp;
      px.red_in   = rgb[23:16];
      px.green_in = rgb[15:8];
      px.blue_in  = rgb[7:0];
      return px;
   endfunction

   function automatic sngf_pkg::req_type random_pixel(input int sample_pct);
      return make_pixel($urandom_range(0, 99) < sample_pct,
                        {pick_channel(), pick_channel(), pick_channel()});
   endfunction

   function automatic logic [sngf_pkg::CSR_W-1:0] pick_width();
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0: return 13'd1;
         1: return 13'd2;
         2: return 13'd0;
         3: return 13'd8191;
         4: return 13'd4096;
         5, 6, 7: return sngf_pkg::CSR_W'($urandom_range(25, 300));
         default: return sngf_pkg::CSR_W'($urandom_range(3, 24));
      endcase
   endfunction

   // offer one pixel beat, with an optional gap before it
   task automatic send_pixel(input sngf_pkg::req_type px);
      int gap;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 4);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (req_full);
      pixels_sent++;
   endtask

   task automatic send_hole();
      send_pixel(make_pixel(1'b0, 24'($urandom)));
   endtask

   task automatic drain_runs();
      req_push <= 1'b0;
      // the checker counts on the same edge, so look from the next one on
      @(posedge clock);
      while (pending_runs != 0)
         @(posedge clock);
      // let a trailing hole clear the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_row_width(input logic [sngf_pkg::CSR_W-1:0] value);
      drain_runs();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      width_writes++;
   endtask

   task automatic random_chunks(input int item_count);
      int sent;
      int chunk;
      int pct;
      sent = 0;
      while (sent < item_count) begin
         write_row_width(pick_width());
         chunk = $urandom_range(15, 40);
         case ($urandom_range(0, 2))
            0: pct = 15;
            1: pct = 50;
            default: pct = 90;
         endcase
         for (int k = 0; k < chunk; k++)
            send_pixel(random_pixel(pct));
         sent += chunk;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 13;
      recv_idle_pct = 85;

      // directed: reset width, split runs, adjacent samples repaint the left one
      send_pixel(make_pixel(1'b1, 24'hff00ff));
      send_hole();
      send_pixel(make_pixel(1'b1, 24'h00ff00));
      send_pixel(make_pixel(1'b1, 24'h123456));
      send_hole();
      // shrink the width mid-row: the next pixel ends the row with a tail
      write_row_width(13'd6);
      send_hole();
      send_hole();
      send_hole();
      send_pixel(make_pixel(1'b1, 24'hffffff));
      send_hole();
      send_hole();
      send_pixel(make_pixel(1'b1, 24'h000000));
      repeat (6) send_hole();
      // zero width acts as one pixel per row
      write_row_width(13'd0);
      send_pixel(make_pixel(1'b1, 24'hffffff));
      send_hole();
      send_pixel(make_pixel(1'b1, 24'h000000));
      // tail skipped when the last sample lies past the shrunk width
      write_row_width(13'd10);
      repeat (7) send_hole();
      send_pixel(make_pixel(1'b1, 24'ha5a5a5));
      write_row_width(13'd5);
      send_hole();
      write_row_width(13'd2);
      send_pixel(make_pixel(1'b1, 24'h5a5a5a));
      send_pixel(make_pixel(1'b1, 24'hc3c3c3));

      random_chunks(100);

      send_idle_pct = 85;
      recv_idle_pct = 13;
      random_chunks(100);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_chunks(40);

      // pause until every run is out, then stall the receiver while pixels keep coming
      drain_runs();
      write_row_width(13'd6);
      hold_request = 1'b1;
      for (int k = 0; k < 60; k++)
         send_pixel(random_pixel(90));

      // oversized width acts as the cap until a shrink ends the row
      write_row_width(13'd8191);
      send_pixel(make_pixel(1'b1, 24'h0f0f0f));
      repeat (3) send_hole();
      write_row_width(13'd2);
      send_pixel(make_pixel(1'b1, 24'h3c3c3c));

      drain_runs();
      repeat (20) @(posedge clock);

      $display("covered %0d pixels across %0d width settings, including mid-row shrinks,",
               pixels_sent, width_writes);
      $display("clamped widths and a stalled receiver; %0d fill runs compared",
               runs_checked);
      if (fail_count == 0 && pending_runs == 0)
         $display("scanline_nearest_gap_fill regression: pass");
      else
         $display("scanline_nearest_gap_fill regression: fail");
      $finish;
   end

endmodule

>>> sim.f
src/sngf_pkg.sv
src/sngf_queue.sv
src/sngf_front.sv
src/sngf_back.sv
src/scanline_nearest_gap_fill.sv
bench/sngf_run_checker.sv
bench/scanline_nearest_gap_fill_tb.sv
